FILE: sv/tcpt_pkg.sv
package tcpt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_TRAVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_INT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_STEP = 2'd2;

  // operations
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_UP   = 3'd1;
  localparam logic [2:0] OP_DOWN = 3'd2;
  localparam logic [2:0] OP_STOP = 3'd3;
  localparam logic [2:0] OP_PCT  = 3'd4;

  // event kinds
  localparam logic [2:0] EV_PRESS_UP   = 3'd0;
  localparam logic [2:0] EV_PRESS_DOWN = 3'd1;
  localparam logic [2:0] EV_PRESS_STOP = 3'd2;
  localparam logic [2:0] EV_REP_UP     = 3'd3;
  localparam logic [2:0] EV_REP_DOWN   = 3'd4;
  localparam logic [2:0] EV_REP_STOP   = 3'd5;
  localparam logic [2:0] EV_REP_PCT    = 3'd6;

  localparam logic signed [8:0] GOAL_UP   = -9'sd20;
  localparam logic signed [8:0] GOAL_DOWN = 9'sd120;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] target_percent;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [6:0] report_percent;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_START_DOWN,
    UPD_START_UP,
    UPD_STOP,
    UPD_STEP
  } upd_t;

  typedef struct packed {
    logic       apply_cmd;
    logic       tick_start;
    logic       t1;
    logic       t2;
    upd_t       upd;
    logic       load_out;
    logic [2:0] kind;
    logic       last;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
    logic pending;
    logic status_emit;
    logic gt;
    logic lt;
    logic late;
    logic inwin;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/tcpt_dp.sv
module tcpt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcpt_pkg::in_word_t              in_word,
  input  logic                            cfg_we,
  input  logic [tcpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcpt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  tcpt_pkg::ctl_cmd_t              cmd,
  output tcpt_pkg::dp_status_t            sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output tcpt_pkg::out_word_t             out_word
);
  import tcpt_pkg::*;

  logic [7:0]  fts_r;
  logic [15:0] interval_r;
  logic [6:0]  step_r;

  logic [31:0]       now_r;
  logic signed [8:0] goal_r;
  logic signed [8:0] pos_r;
  logic              dir_up_r;
  logic              moving_r;
  logic              pending_r;
  logic [31:0]       start_r;
  logic [31:0]       end_r;
  logic [7:0]        progress_r;
  logic [31:0]       next_status_r;

  logic        busy_r;
  logic        status_emit_r;
  logic [19:0] prod_a_r;
  logic [20:0] prod_b_r;
  logic [26:0] prod_c_r;

  logic        out_valid_r;
  out_word_t   out_word_r;

  logic [11:0]        per1;
  logic signed [9:0]  diff;
  logic [9:0]         diff_neg;
  logic [8:0]         span;
  logic [6:0]         pct;
  logic signed [10:0] stepped;
  logic signed [8:0]  pos_step;
  logic [31:0]        due;
  logic               status_hit;
  logic               busy_now;

  always_comb begin
    // ms per percent = 10 * full travel seconds
    per1 = {1'b0, fts_r, 3'b000} + {3'b000, fts_r, 1'b0};
    diff = {goal_r[8], goal_r} - {pos_r[8], pos_r};
    diff_neg = 10'(-diff);
    span = diff[9] ? diff_neg[8:0] : diff[8:0];

    if (pos_r < 9'sd0) begin
      pct = 7'd0;
    end else if (pos_r > 9'sd100) begin
      pct = 7'd100;
    end else begin
      pct = pos_r[6:0];
    end

    if (dir_up_r) begin
      stepped = {{2{pos_r[8]}}, pos_r} - $signed({4'b0000, step_r});
    end else begin
      stepped = {{2{pos_r[8]}}, pos_r} + $signed({4'b0000, step_r});
    end
    if (stepped < -11'sd256) begin
      pos_step = -9'sd256;
    end else if (stepped > 11'sd255) begin
      pos_step = 9'sd255;
    end else begin
      pos_step = stepped[8:0];
    end

    due = start_r + {5'b0, prod_c_r};
    status_hit = (next_status_r <= now_r);
    busy_now = pending_r | moving_r;
  end

  always_comb begin
    sts.busy        = busy_r;
    sts.pending     = pending_r;
    sts.status_emit = status_emit_r;
    sts.gt          = goal_r > pos_r;
    sts.lt          = goal_r < pos_r;
    sts.late        = now_r > due;
    sts.inwin       = now_r <= end_r;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fts_r         <= 8'd30;
      interval_r    <= 16'd1000;
      step_r        <= 7'd10;
      now_r         <= '0;
      goal_r        <= '0;
      pos_r         <= '0;
      dir_up_r      <= 1'b0;
      moving_r      <= 1'b0;
      pending_r     <= 1'b0;
      start_r       <= '0;
      end_r         <= '0;
      progress_r    <= '0;
      next_status_r <= '0;
      busy_r        <= 1'b0;
      status_emit_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FULL_TRAVEL: fts_r      <= cfg_data[7:0];
          CFG_STATUS_INT:  interval_r <= cfg_data;
          CFG_REPORT_STEP: step_r     <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (cmd.apply_cmd) begin
        pending_r <= 1'b1;
        unique case (in_word.operation)
          OP_UP:   goal_r <= GOAL_UP;
          OP_DOWN: goal_r <= GOAL_DOWN;
          OP_STOP: begin
            goal_r <= pos_r;
            end_r  <= now_r;
          end
          OP_PCT:  goal_r <= $signed({2'b00, in_word.target_percent}) - 9'sd1;
          default: ;
        endcase
      end

      if (cmd.tick_start) begin
        now_r <= now_r + 32'd1;
      end

      if (cmd.t1) begin
        busy_r <= busy_now;
        if (!busy_now) begin
          pos_r <= $signed({2'b00, pct});
        end
        if (status_hit) begin
          next_status_r <= now_r + {16'b0, interval_r};
        end
        status_emit_r <= status_hit && !busy_now;
        prod_a_r <= 20'(per1) * 20'(progress_r);
        prod_b_r <= 21'(span) * 21'(per1);
      end

      if (cmd.t2) begin
        prod_c_r <= 27'(prod_a_r) * 27'(step_r);
      end

      case (cmd.upd)
        UPD_START_DOWN, UPD_START_UP: begin
          dir_up_r   <= (cmd.upd == UPD_START_UP);
          start_r    <= now_r;
          end_r      <= now_r + {11'b0, prod_b_r};
          pending_r  <= 1'b0;
          moving_r   <= 1'b1;
          progress_r <= 8'd1;
        end
        UPD_STOP: begin
          start_r   <= '0;
          end_r     <= '0;
          pending_r <= 1'b0;
          moving_r  <= 1'b0;
        end
        UPD_STEP: begin
          pos_r      <= pos_step;
          progress_r <= progress_r + 8'd1;
        end
        default: ;
      endcase

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.event_kind     <= cmd.kind;
      out_word_r.report_percent <= (cmd.kind == EV_REP_PCT) ? pct : 7'd0;
      out_word_r.last_of_run    <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sv/tcpt_ctrl.sv
module tcpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_op,
  output logic                 in_stall,
  input  tcpt_pkg::dp_status_t sts,
  output tcpt_pkg::ctl_cmd_t   cmd
);
  import tcpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_EMIT
  } state_t;

  // sequence of words to send for one tick
  typedef enum logic [2:0] {
    SC_STATUS,
    SC_DOWN,
    SC_UP,
    SC_STOP,
    SC_STEP
  } script_t;

  state_t     state_r;
  script_t    script_r;
  script_t    script_nxt;
  logic       has_emit;
  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic [2:0] kind;
  logic       accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    script_nxt = SC_STATUS;
    has_emit   = 1'b0;
    if (sts.status_emit) begin
      script_nxt = SC_STATUS;
      has_emit   = 1'b1;
    end else if (sts.busy && sts.pending) begin
      has_emit = 1'b1;
      if (sts.gt) begin
        script_nxt = SC_DOWN;
      end else if (sts.lt) begin
        script_nxt = SC_UP;
      end else begin
        script_nxt = SC_STOP;
      end
    end else if (sts.busy) begin
      if (!sts.inwin) begin
        script_nxt = SC_STOP;
        has_emit   = 1'b1;
      end else if (sts.late) begin
        script_nxt = SC_STEP;
        has_emit   = 1'b1;
      end
    end
  end

  always_comb begin
    kind     = EV_REP_PCT;
    last_idx = 2'd0;
    unique case (script_r)
      SC_STATUS: begin
        last_idx = 2'd1;
        kind     = (idx_r == 2'd0) ? EV_REP_STOP : EV_REP_PCT;
      end
      SC_DOWN: begin
        last_idx = 2'd1;
        kind     = (idx_r == 2'd0) ? EV_PRESS_DOWN : EV_REP_DOWN;
      end
      SC_UP: begin
        last_idx = 2'd1;
        kind     = (idx_r == 2'd0) ? EV_PRESS_UP : EV_REP_UP;
      end
      SC_STOP: begin
        last_idx = 2'd2;
        case (idx_r)
          2'd0:    kind = EV_PRESS_STOP;
          2'd1:    kind = EV_REP_STOP;
          default: kind = EV_REP_PCT;
        endcase
      end
      SC_STEP: begin
        last_idx = 2'd0;
        kind     = EV_REP_PCT;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.apply_cmd  = accept && (in_op == OP_UP || in_op == OP_DOWN ||
                                in_op == OP_STOP || in_op == OP_PCT);
    cmd.tick_start = accept && (in_op == OP_TICK);
    cmd.t1         = (state_r == ST_T1);
    cmd.t2         = (state_r == ST_T2);
    cmd.upd        = UPD_NONE;
    if (state_r == ST_T3 && has_emit) begin
      unique case (script_nxt)
        SC_DOWN: cmd.upd = UPD_START_DOWN;
        SC_UP:   cmd.upd = UPD_START_UP;
        SC_STOP: cmd.upd = UPD_STOP;
        SC_STEP: cmd.upd = UPD_STEP;
        default: cmd.upd = UPD_NONE;
      endcase
    end
    cmd.load_out = (state_r == ST_EMIT) && sts.out_free;
    cmd.kind     = kind;
    cmd.last     = (idx_r == last_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      script_r <= SC_STATUS;
      idx_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.tick_start) begin
            state_r <= ST_T1;
          end
        end
        ST_T1: state_r <= ST_T2;
        ST_T2: state_r <= ST_T3;
        ST_T3: begin
          script_r <= script_nxt;
          idx_r    <= '0;
          state_r  <= has_emit ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (sts.out_free) begin
            if (idx_r == last_idx) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/timed_cover_position_tracker.sv
// Command words (up, down, stop, go to percent) are taken when idle and give no result.
// A tick word passes through the tick sequencer (status check, two multiply stages, time
// compare), then goes one result word per cycle into the output register when not stalled.
// No new word is taken until all n result words of a tick (n is 0 to 3) are loaded.
// Reset (rst_n, synchronous, active low) zeroes position, goal and all times and loads
// the register defaults: 30 s full travel, 1000 ms status interval, 10 percent step.
module timed_cover_position_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcpt_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcpt_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [tcpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcpt_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  tcpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: sv/tcpt_checker.sv
module tcpt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tcpt_pkg::out_word_t out_word
);
  import tcpt_pkg::*;

  // a press is always followed by its report in the same run
  ast_press_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.event_kind == EV_PRESS_UP ||
                  out_word.event_kind == EV_PRESS_DOWN ||
                  out_word.event_kind == EV_PRESS_STOP) |-> !out_word.last_of_run)
    else $error("press word marked last");

  // percent report always closes a run
  ast_pct_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.event_kind == EV_REP_PCT |-> out_word.last_of_run)
    else $error("percent report not last");

  ast_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.report_percent <= 7'd100 &&
                  (out_word.event_kind == EV_REP_PCT || out_word.report_percent == 7'd0))
    else $error("report_percent out of range or set on non-percent word");

  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

endmodule

bind timed_cover_position_tracker tcpt_checker u_tcpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

FILE: tb/tb_timed_cover_position_tracker.sv
`timescale 1ns / 100ps
module tb_timed_cover_position_tracker;
  import tcpt_pkg::*;

  localparam int NO_ACCEPT_LIMIT = 4000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int POS_LO          = -256;
  localparam int POS_HI          = 255;
  localparam int MAX_EVENTS      = 5;

  // register slot that the block does not implement
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // operation codes that the block ignores
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_COMB
  } stall_style_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  timed_cover_position_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // cover tracker shadow: registers and state
  logic [7:0]  travel_s;
  logic [15:0] status_gap_ms;
  logic [6:0]  step_pct;
  logic [31:0] now_ms;
  logic [31:0] move_t0;
  logic [31:0] move_t1;
  logic [31:0] status_due_ms;
  logic [7:0]  step_no;
  int          goal_pos;
  int          cur_pos;
  int          dir;
  bit          moving;
  bit          pending;

  out_word_t   tick_events[$];
  out_word_t   events_due[$];
  in_word_t    words_to_send[$];
  int          errors = 0;
  logic        word_taken = 1'b0;

  function automatic void post_event(logic [2:0] kind);
    out_word_t w;
    int        p;
    p = (cur_pos > 100) ? 100 : ((cur_pos < 0) ? 0 : cur_pos);
    w.event_kind     = kind;
    w.report_percent = (kind == EV_REP_PCT) ? 7'(p) : 7'd0;
    w.last_of_run    = 1'b0;
    if (tick_events.size() < MAX_EVENTS) tick_events.push_back(w);
  endfunction

  function automatic logic [31:0] ms_per_pct();
    return 32'(travel_s) * 32'd10;
  endfunction

  function automatic void begin_travel(int d);
    int span;
    span    = (goal_pos - cur_pos) * d;
    dir     = d;
    move_t0 = now_ms;
    move_t1 = now_ms + 32'(span) * ms_per_pct();
    pending = 1'b0;
    moving  = 1'b1;
    step_no = 8'd1;
  endfunction

  function automatic void end_travel();
    post_event(EV_PRESS_STOP);
    move_t0 = '0;
    move_t1 = '0;
    pending = 1'b0;
    moving  = 1'b0;
    post_event(EV_REP_STOP);
    post_event(EV_REP_PCT);
  endfunction

  function automatic void advance_motion();
    logic [31:0] due;
    int          np;
    if (pending) begin
      if (goal_pos > cur_pos) begin
        post_event(EV_PRESS_DOWN);
        begin_travel(1);
        post_event(EV_REP_DOWN);
      end else if (goal_pos < cur_pos) begin
        post_event(EV_PRESS_UP);
        begin_travel(-1);
        post_event(EV_REP_UP);
      end else begin
        end_travel();
      end
    end else if (moving) begin
      if (now_ms <= move_t1) begin
        due = move_t0 + ms_per_pct() * 32'(step_no) * 32'(step_pct);
        if (now_ms > due) begin
          np      = cur_pos + int'(step_pct) * dir;
          cur_pos = (np < POS_LO) ? POS_LO : ((np > POS_HI) ? POS_HI : np);
          step_no = step_no + 8'd1;
          post_event(EV_REP_PCT);
        end
      end else begin
        end_travel();
      end
    end
  endfunction

  function automatic void track_cover_word(in_word_t w);
    bit        busy;
    out_word_t ev;
    tick_events.delete();
    case (w.operation)
      OP_TICK: begin
        now_ms = now_ms + 32'd1;
        busy   = pending || moving;
        if (!busy) begin
          if (cur_pos > 100) cur_pos = 100;
          if (cur_pos < 0) cur_pos = 0;
        end
        if (status_due_ms <= now_ms) begin
          if (!pending && !moving) begin
            post_event(EV_REP_STOP);
            post_event(EV_REP_PCT);
          end
          status_due_ms = now_ms + 32'(status_gap_ms);
        end
        if (busy) advance_motion();
      end
      OP_UP: begin
        goal_pos = int'(GOAL_UP);
        pending  = 1'b1;
      end
      OP_DOWN: begin
        goal_pos = int'(GOAL_DOWN);
        pending  = 1'b1;
      end
      OP_STOP: begin
        goal_pos = cur_pos;
        move_t1  = now_ms;
        pending  = 1'b1;
      end
      OP_PCT: begin
        goal_pos = int'(w.target_percent) - 1;
        pending  = 1'b1;
      end
      default: ;
    endcase
    foreach (tick_events[i]) begin
      ev             = tick_events[i];
      ev.last_of_run = (i == tick_events.size() - 1);
      events_due.push_back(ev);
    end
  endfunction

  // result checker, then prediction for a word taken at this edge
  always @(posedge clk) begin : monitor
    out_word_t exp_w;
    word_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: kind %0d pct %0d last %0b", $time,
                 out_word.event_kind, out_word.report_percent, out_word.last_of_run);
      end else begin
        exp_w = events_due.pop_front();
        if (out_word.event_kind !== exp_w.event_kind ||
            out_word.report_percent !== exp_w.report_percent ||
            out_word.last_of_run !== exp_w.last_of_run) begin
          errors++;
          $display("%0t: mismatch: expected kind %0d pct %0d last %0b, got kind %0d pct %0d last %0b",
                   $time, exp_w.event_kind, exp_w.report_percent, exp_w.last_of_run,
                   out_word.event_kind, out_word.report_percent, out_word.last_of_run);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) track_cover_word(in_word);
  end

  // sender: bursts of words with random gaps between them
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        in_word  <= words_to_send.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: segments of different stall styles, plus a periodic long hold-off
  // (first one early, while the first random phase is still sending)
  int           rx_cycle = 0;
  int           rx_hold  = 0;
  int           rx_seg   = 0;
  stall_style_t rx_style = STALL_NONE;
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_cycle % 1500 == 300) begin
      rx_hold = 250;
      out_stall <= 1'b1;
    end else begin
      if (rx_seg == 0) begin
        rx_seg   = $urandom_range(4, 50);
        rx_style = stall_style_t'($urandom_range(0, 3));
      end
      rx_seg--;
      case (rx_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= NO_ACCEPT_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void queue_word(logic [2:0] op, logic [6:0] tgt);
    in_word_t w;
    w.operation      = op;
    w.target_percent = tgt;
    words_to_send.push_back(w);
  endfunction

  // mostly a command followed by a run of ticks; the rest single random words
  function automatic void fill_random(int n);
    int         made;
    int         runlen;
    int         pick;
    logic [2:0] op;
    logic [6:0] tgt;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 9);
        tgt  = 7'($urandom);
        if (pick < 2) op = OP_UP;
        else if (pick < 4) op = OP_DOWN;
        else if (pick < 5) op = OP_STOP;
        else begin
          op = OP_PCT;
          if ($urandom_range(0, 4) != 0) tgt = 7'($urandom_range(0, 100));
        end
        queue_word(op, tgt);
        made++;
        runlen = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 200) : $urandom_range(3, 40);
        if (runlen > n - made) runlen = n - made;
        repeat (runlen) queue_word(OP_TICK, 7'($urandom));
        made += runlen;
      end else begin
        op = 3'($urandom);
        queue_word(op, 7'($urandom));
        if (op <= OP_PCT) made++;
      end
    end
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FULL_TRAVEL: travel_s      = val[7:0];
      CFG_STATUS_INT:  status_gap_ms = val;
      CFG_REPORT_STEP: step_pct      = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every word is sent and every result is in, then let the block go quiet
  task automatic settle();
    while (words_to_send.size() != 0 || in_valid || events_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // upper data bits beyond a register's width are junk and must be dropped
  task automatic run_phase(logic [7:0] travel, logic [15:0] interval, logic [6:0] step,
                           int n);
    settle();
    cfg_write(CFG_FULL_TRAVEL, {8'($urandom), travel});
    cfg_write(CFG_STATUS_INT, interval);
    cfg_write(CFG_REPORT_STEP, {9'($urandom), step});
    fill_random(n);
  endtask

  initial begin
    travel_s      = 8'd30;
    status_gap_ms = 16'd1000;
    step_pct      = 7'd10;
    now_ms        = '0;
    move_t0       = '0;
    move_t1       = '0;
    status_due_ms = '0;
    step_no       = '0;
    goal_pos      = 0;
    cur_pos       = 0;
    dir           = 0;
    moving        = 1'b0;
    pending       = 1'b0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings
    queue_word(OP_TICK, 7'h7F);             // first status report
    queue_word(OP_UNUSED_LO, 7'h7F);
    queue_word(OP_UNUSED_LO + 3'd1, 7'h55);
    queue_word(OP_UNUSED_HI, 7'h2A);
    queue_word(OP_STOP, 7'h00);             // stop at rest: goal equals position
    queue_word(OP_TICK, 7'h00);
    queue_word(OP_PCT, 7'd0);               // goal below zero
    queue_word(OP_TICK, 7'h33);
    queue_word(OP_TICK, 7'h4C);
    queue_word(OP_STOP, 7'h7F);
    queue_word(OP_TICK, 7'h01);
    queue_word(OP_PCT, 7'd1);               // goal zero, already there
    queue_word(OP_TICK, 7'h7E);
    queue_word(OP_PCT, 7'd127);             // out of range, taken as given
    queue_word(OP_TICK, 7'h00);
    queue_word(OP_UP, 7'h7F);
    queue_word(OP_TICK, 7'h3F);
    queue_word(OP_DOWN, 7'h00);
    queue_word(OP_TICK, 7'h40);
    queue_word(OP_PCT, 7'd100);
    queue_word(OP_TICK, 7'h2B);
    queue_word(OP_STOP, 7'h54);
    queue_word(OP_TICK, 7'h7F);
    queue_word(OP_TICK, 7'h00);

    settle();
    cfg_write(CFG_SPARE, 16'($urandom));
    run_phase(8'd1, 16'd5, 7'd1, 70);
    run_phase(8'd1, 16'd1, 7'd3, 60);
    run_phase(8'd0, 16'd0, 7'd0, 30);       // all registers zero
    run_phase(8'd1, 16'd3, 7'd0, 40);       // zero step with motion
    run_phase(8'd2, 16'd20, 7'd100, 40);
    run_phase(8'($urandom_range(1, 4)), 16'($urandom_range(1, 200)),
              7'($urandom_range(1, 20)), 60);
    run_phase(8'($urandom_range(1, 4)), 16'($urandom_range(1, 200)),
              7'($urandom_range(1, 20)), 60);
    // long intervals last, they push the next status report far out
    run_phase(8'd1, 16'd65535, 7'd1, 40);
    run_phase(8'd255, 16'd65535, 7'd100, 20);
    settle();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: timed_cover_position_tracker.f
sv/tcpt_pkg.sv
sv/tcpt_dp.sv
sv/tcpt_ctrl.sv
sv/timed_cover_position_tracker.sv
sv/tcpt_checker.sv
tb/tb_timed_cover_position_tracker.sv
